/* rtl/core/plin_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plin_pkg: shared types and constants of the piecewise linear lookup
// Table geometry, field widths, item codes and the divider status struct.
// ----------------------------------------------------------------------------
package plin_pkg;

    localparam int PTS_MAX   = 64;                    // table depth
    localparam int ADDR_W    = $clog2(PTS_MAX);       // table address
    localparam int CNT_W     = $clog2(PTS_MAX + 1);   // scan count, holds PTS_MAX
    localparam int CFG_W     = 7;                     // points_in_use register
    localparam int IDX_FLD_W = 6;                     // point_index field
    localparam int DATA_W    = 32;                    // Q16.16 word
    localparam int ENTRY_W   = 2 * DATA_W;            // key and value together
    localparam int S_DATA_W  = 104;                   // input tdata, whole bytes
    localparam int DVD_W     = 2 * DATA_W;            // dividend width
    localparam int DSTEP_W   = $clog2(DVD_W + 1);     // divide step counter

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/core/plin_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plin_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plin_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/plin_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plin_divider: iterative unsigned restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plin_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [plin_pkg::DVD_W-1:0]    dividend,
    input  logic [plin_pkg::DATA_W-1:0]   divisor,
    output logic [plin_pkg::DVD_W-1:0]    quotient,
    output plin_pkg::div_status_t         status
);
    import plin_pkg::*;

    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [DATA_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0]  dsr_reg, dsr_next;
    logic [DSTEP_W-1:0] step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DATA_W:0]    shifted;
    logic [DATA_W+1:0]  diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = DSTEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not go negative
            if (!diff[DATA_W+1])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == DSTEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/core/piecewise_linear_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_lookup: breakpoint table with linear interpolation
// Loads Q16.16 breakpoints and answers queries by scan, multiply and divide.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata (point fields), s_tuser (operation)
//  m_*       out  m_tvalid / m_tready  m_tdata (result_y), m_tuser (result_valid)
//  cfg_*     in   cfg_valid / cfg_ready cfg_data (points_in_use)
//
//  A load item writes the table RAM at the accept edge.
//  A query steps in order through accepting the item, issuing the first
//  table read, one read per table entry through the RAM read port, the
//  multiply, starting the divider, one divide step per quotient bit,
//  handing over the quotient and posting the result.
//  A query that ends at a match or out of range skips multiply and divide.
//  s_tready is high only while the sequencer is idle; a result waiting in the
//  output register does not block the next item, only the next result.
//  Reset clears the sequencer, the output register and points_in_use; the
//  table itself holds whatever was last loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_lookup (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [5:0] point_index, [37:6] point_key, [69:38] point_value,
    // [101:70] query_x, [103:102] zero
    input  logic [plin_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                           s_tuser,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] result_y
    output logic [plin_pkg::DATA_W-1:0]    m_tdata,
    // [0] result_valid
    output logic                           m_tuser,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [plin_pkg::CFG_W-1:0]     cfg_data
);
    import plin_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0]  points_reg, points_next;
    logic [CNT_W-1:0]  n_lim;

    // scan control
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              have_low_reg, have_low_next;

    // query operands
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] x1_reg, x1_next;
    logic signed [DATA_W-1:0] y1_reg, y1_next;
    logic [DATA_W-1:0]  dx_reg, dx_next;
    logic [DATA_W-1:0]  den_reg, den_next;
    logic [DATA_W:0]    mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [DVD_W-1:0]   prod_reg, prod_next;

    // pending result and output register
    logic [DATA_W-1:0]  res_y_reg, res_y_next;
    logic               res_ok_reg, res_ok_next;
    logic               out_vld_reg, out_vld_next;
    logic [DATA_W-1:0]  out_y_reg, out_y_next;
    logic               out_ok_reg, out_ok_next;

    // input fields
    logic [IDX_FLD_W-1:0]     ld_index;
    logic [DATA_W-1:0]        ld_key;
    logic [DATA_W-1:0]        ld_value;
    logic signed [DATA_W-1:0] q_x;
    logic                     s_accept;

    // table access
    logic                     ram_wr_en;
    logic                     ram_rd_en;
    logic [ENTRY_W-1:0]       ram_rd_data;
    logic signed [DATA_W-1:0] ent_key;
    logic signed [DATA_W-1:0] ent_val;

    // interpolation terms
    logic [DATA_W:0]          dx_wide;
    logic [DATA_W:0]          den_wide;
    logic signed [DATA_W:0]   dy_wide;
    logic [DATA_W*2:0]        prod_wide;

    // divider
    logic                     div_start;
    logic [DVD_W-1:0]         div_quo;
    div_status_t              div_stat;

    assign ld_index = s_tdata[IDX_FLD_W-1:0];
    assign ld_key   = s_tdata[IDX_FLD_W +: DATA_W];
    assign ld_value = s_tdata[IDX_FLD_W+DATA_W +: DATA_W];
    assign q_x      = s_tdata[IDX_FLD_W+2*DATA_W +: DATA_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // a count above the table depth searches the whole table
    assign n_lim = (points_reg > CFG_W'(PTS_MAX)) ? CNT_W'(PTS_MAX) : CNT_W'(points_reg);

    // drop loads aimed beyond the table
    assign ram_wr_en = s_accept && (op_t'(s_tuser) == OP_LOAD)
                       && (CNT_W'(ld_index) < CNT_W'(PTS_MAX));
    assign ram_rd_en = (state_reg == ST_SCAN) && (idx_reg < n_lim);

    plin_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PTS_MAX)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ld_index[ADDR_W-1:0]),
        .wr_data ({ld_value, ld_key}),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign ent_key = ram_rd_data[DATA_W-1:0];
    assign ent_val = ram_rd_data[ENTRY_W-1:DATA_W];

    // differences against the kept lower point; dx and den are positive here
    assign dx_wide   = 33'({x_reg[DATA_W-1], x_reg} - {x1_reg[DATA_W-1], x1_reg});
    assign den_wide  = 33'({ent_key[DATA_W-1], ent_key} - {x1_reg[DATA_W-1], x1_reg});
    assign dy_wide   = $signed({ent_val[DATA_W-1], ent_val} - {y1_reg[DATA_W-1], y1_reg});
    assign prod_wide = dx_reg * mag_reg;

    assign div_start = (state_reg == ST_START);

    plin_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .quotient (div_quo),
        .status   (div_stat)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_y_reg;
    assign m_tuser  = out_ok_reg;

    always_comb
    begin
        state_next    = state_reg;
        points_next   = points_reg;
        idx_next      = idx_reg;
        rd_vld_next   = rd_vld_reg;
        have_low_next = have_low_reg;
        x_next        = x_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        dx_next       = dx_reg;
        den_next      = den_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        res_y_next    = res_y_reg;
        res_ok_next   = res_ok_reg;
        out_vld_next  = out_vld_reg;
        out_y_next    = out_y_reg;
        out_ok_next   = out_ok_reg;

        if (cfg_valid && cfg_ready)
        begin
            points_next = cfg_data;
        end

        // release the output register once the item is taken
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && (op_t'(s_tuser) == OP_QUERY))
                begin
                    x_next        = q_x;
                    idx_next      = '0;
                    rd_vld_next   = 1'b0;
                    have_low_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_vld_reg && (ent_key == x_reg))
                begin
                    // exact match
                    res_y_next  = ent_val;
                    res_ok_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (rd_vld_reg && (ent_key > x_reg))
                begin
                    if (!have_low_reg)
                    begin
                        res_y_next  = '0;
                        res_ok_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        dx_next    = dx_wide[DATA_W-1:0];
                        den_next   = den_wide[DATA_W-1:0];
                        neg_next   = dy_wide[DATA_W];
                        mag_next   = dy_wide[DATA_W] ? 33'(-dy_wide) : 33'(dy_wide);
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    if (rd_vld_reg)
                    begin
                        // key below x: keep it as the lower point
                        have_low_next = 1'b1;
                        x1_next       = ent_key;
                        y1_next       = ent_val;
                    end
                    if (idx_reg < n_lim)
                    begin
                        idx_next    = idx_reg + 1'b1;
                        rd_vld_next = 1'b1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                        if (!rd_vld_reg)
                        begin
                            // ran off the end of the table
                            res_y_next  = '0;
                            res_ok_next = 1'b0;
                            state_next  = ST_FINISH;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = prod_wide[DVD_W-1:0];
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_y_next  = neg_reg ? (y1_reg - div_quo[DATA_W-1:0])
                                          : (y1_reg + div_quo[DATA_W-1:0]);
                    res_ok_next = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next = 1'b1;
                    out_y_next   = res_y_reg;
                    out_ok_next  = res_ok_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            points_reg   <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            have_low_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_y_reg    <= '0;
            out_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            points_reg   <= points_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            have_low_reg <= have_low_next;
            out_vld_reg  <= out_vld_next;
            out_y_reg    <= out_y_next;
            out_ok_reg   <= out_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        dx_reg     <= dx_next;
        den_reg    <= den_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        res_y_reg  <= res_y_next;
        res_ok_reg <= res_ok_next;
    end

    // an out-of-range result always carries a zero value
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid result with nonzero value");

    // the divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (state_reg == ST_DIV))
        else $error("divider active outside divide state");

    // the scan index never passes the table depth
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= CNT_W'(PTS_MAX)))
        else $error("scan index beyond table");

endmodule
